FILE: rtl/core/rpre_pkg.sv
// Shared types and constants of the register poll read engine.
`default_nettype none

package rpre_pkg;

  localparam int IDX_W    = 3;
  localparam int REPLY_W  = 24;
  localparam int QDEPTH   = 2;

  // Request frame and reply layout
  localparam logic [7:0] LEN_CODE   = 8'h07;
  localparam logic [2:0] LAST_BYTE  = 3'd6;   // last byte of the 7-byte request
  localparam logic [2:0] LAST_REPLY = 3'd5;   // last byte of the 6-byte reply

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_CODES   = 3'd0;
  localparam logic [2:0] CFG_POLL_INTERVAL = 3'd1;
  localparam logic [2:0] CFG_REPLY_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_ADDR_LOW      = 3'd3;
  localparam logic [2:0] CFG_ADDR_HIGH     = 3'd4;
  localparam logic [2:0] CFG_SKIP_MASK     = 3'd5;

  // Input item types
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_VALID = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  // One unit of work handed from the front to the back
  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   item;
    logic [REPLY_W-1:0] reading;
    logic               round_done;
  } job_t;

  // One result transaction
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tx_byte;
    logic [IDX_W-1:0]   item;
    logic [REPLY_W-1:0] reading;
    logic               round_done;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [15:0] reply_timeout;
    logic [7:0]  skip_mask;
    logic [7:0]  ack_code;
  } front_cfg_t;

  typedef struct packed {
    logic [31:0] frame_codes;
    logic [63:0] addr_low;
    logic [63:0] addr_high;
  } back_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/rpre_front.sv
// Front end: accepts ticks and reply bytes, runs the poll state and issues jobs.
`default_nettype none

module rpre_front #(
  parameter int ITEM_COUNT    = 8,
  parameter int SEND_ATTEMPTS = 2
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire rpre_pkg::front_cfg_t cfg,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     req_type,
  input  wire  [7:0]              rx_byte,
  input  wire                     q_full,
  output logic                    push,
  output rpre_pkg::job_t          job
);
  import rpre_pkg::*;

  localparam int RCW = $clog2(SEND_ATTEMPTS + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_WAIT = 2'b10
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [RCW-1:0]   retry_r, retry_nxt;
  logic [15:0]      rtimer_r, rtimer_nxt;
  logic [15:0]      itimer_r, itimer_nxt;
  logic [2:0]       rcount_r, rcount_nxt;
  logic             round_r, round_nxt;
  logic [7:0]       rbuf_r [5];

  logic             accept;
  logic             buf_we;
  logic [IDX_W:0]   ptr_inc;
  logic             wrap;
  logic [IDX_W-1:0] ptr_adv;
  logic             round_adv;
  logic [15:0]      itimer_inc;
  logic [15:0]      rtimer_inc;
  logic [RCW-1:0]   retry_inc;
  logic [7:0]       sum5;
  logic             good;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Item advance with wrap at the table size
  assign ptr_inc   = {1'b0, ptr_r} + {{IDX_W{1'b0}}, 1'b1};
  assign wrap      = ptr_inc >= (IDX_W+1)'(ITEM_COUNT);
  assign ptr_adv   = wrap ? '0 : ptr_inc[IDX_W-1:0];
  assign round_adv = round_r || wrap;

  // Saturating timers
  assign itimer_inc = (itimer_r == 16'hFFFF) ? itimer_r : itimer_r + 16'd1;
  assign rtimer_inc = (rtimer_r == 16'hFFFF) ? rtimer_r : rtimer_r + 16'd1;
  assign retry_inc  = retry_r + RCW'(1);

  // Reply check: ack code first, checksum in the final byte
  assign sum5 = rbuf_r[0] + rbuf_r[1] + rbuf_r[2] + rbuf_r[3] + rbuf_r[4];
  assign good = (rbuf_r[0] == cfg.ack_code) && (8'(8'd0 - sum5) == rx_byte);

  // Next state and job issue
  always_comb begin
    phase_nxt  = phase_r;
    ptr_nxt    = ptr_r;
    retry_nxt  = retry_r;
    rtimer_nxt = rtimer_r;
    itimer_nxt = itimer_r;
    rcount_nxt = rcount_r;
    round_nxt  = round_r;
    push       = 1'b0;
    buf_we     = 1'b0;
    job.kind       = KIND_REQ;
    job.item       = ptr_r;
    job.reading    = '0;
    job.round_done = round_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (req_type == REQ_TICK) begin
            itimer_nxt = itimer_inc;
            if (itimer_inc >= cfg.poll_interval) begin
              if (cfg.skip_mask[ptr_r]) begin
                ptr_nxt    = ptr_adv;
                round_nxt  = round_adv;
                itimer_nxt = '0;
              end else begin
                push       = 1'b1;
                phase_nxt  = PH_WAIT;
                retry_nxt  = '0;
                rtimer_nxt = '0;
                rcount_nxt = '0;
              end
            end
          end
        end
        PH_WAIT: begin
          if (req_type == REQ_BYTE) begin
            if (rcount_r == LAST_REPLY) begin
              rcount_nxt = '0;
              if (good) begin
                push           = 1'b1;
                job.kind       = KIND_VALID;
                job.reading    = {rbuf_r[4], rbuf_r[3], rbuf_r[2]};
                job.round_done = round_adv;
                ptr_nxt        = ptr_adv;
                round_nxt      = round_adv;
                itimer_nxt     = '0;
                phase_nxt      = PH_IDLE;
              end
            end else begin
              buf_we     = 1'b1;
              rcount_nxt = rcount_r + 3'd1;
            end
          end else begin
            rtimer_nxt = rtimer_inc;
            if (rtimer_inc >= cfg.reply_timeout) begin
              if (retry_inc < RCW'(SEND_ATTEMPTS)) begin
                push       = 1'b1;
                retry_nxt  = retry_inc;
                rtimer_nxt = '0;
                rcount_nxt = '0;
              end else begin
                push           = 1'b1;
                job.kind       = KIND_FAIL;
                job.round_done = round_adv;
                ptr_nxt        = ptr_adv;
                round_nxt      = round_adv;
                itimer_nxt     = '0;
                phase_nxt      = PH_IDLE;
                rcount_nxt     = '0;
                retry_nxt      = '0;
              end
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ptr_r    <= '0;
      retry_r  <= '0;
      rtimer_r <= '0;
      itimer_r <= '0;
      rcount_r <= '0;
      round_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      ptr_r    <= ptr_nxt;
      retry_r  <= retry_nxt;
      rtimer_r <= rtimer_nxt;
      itimer_r <= itimer_nxt;
      rcount_r <= rcount_nxt;
      round_r  <= round_nxt;
    end
  end

  // Store reply bytes
  always_ff @(posedge clk) begin
    if (buf_we) begin
      rbuf_r[rcount_r] <= rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (rcount_r == 3'd0))
    else $error("reply count not cleared while idle");
  a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r < RCW'(SEND_ATTEMPTS))
    else $error("retry count beyond send attempts");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rpre_queue.sv
// Two-entry job queue between front and back.
`default_nettype none

module rpre_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire rpre_pkg::job_t push_job,
  output logic             full,
  input  wire              pop,
  output logic             head_valid,
  output rpre_pkg::job_t   head_job
);
  import rpre_pkg::*;

  job_t       mem_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = count_r == 2'(QDEPTH);
  assign head_valid = count_r != 2'd0;
  assign head_job   = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full job queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rpre_back.sv
// Back end: turns jobs into result transactions through an output register, one per cycle while res_ready allows.
`default_nettype none

module rpre_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire rpre_pkg::back_cfg_t cfg,
  input  wire                    q_valid,
  input  wire rpre_pkg::job_t    q_job,
  output logic                   q_pop,
  output logic                   res_valid,
  input  wire                    res_ready,
  output rpre_pkg::res_t         res
);
  import rpre_pkg::*;

  logic       busy_r;
  job_t       job_r;
  logic [2:0] cnt_r;
  logic       out_valid_r;
  res_t       res_r;

  job_t       cur;
  logic [2:0] cur_cnt;
  logic       have;
  logic       out_load;
  logic       emit;
  logic       cur_last;
  logic [63:0] aword;
  logic [15:0] addr;
  logic [7:0]  csum;
  logic [7:0]  fbyte;

  // Pick the job in flight, or the queue head for a fresh one
  assign cur      = busy_r ? job_r : q_job;
  assign cur_cnt  = busy_r ? cnt_r : 3'd0;
  assign have     = busy_r || q_valid;
  assign out_load = !out_valid_r || res_ready;
  assign emit     = have && out_load;
  assign q_pop    = emit && !busy_r;
  assign cur_last = (cur.kind != KIND_REQ) || (cur_cnt == LAST_BYTE);

  // Request frame bytes
  assign aword = cur.item[2] ? cfg.addr_high : cfg.addr_low;
  assign addr  = aword[cur.item[1:0]*16 +: 16];
  assign csum  = 8'(8'd0 - (cfg.frame_codes[7:0] + LEN_CODE + cfg.frame_codes[15:8]
                            + addr[7:0] + addr[15:8] + cfg.frame_codes[23:16]));

  always_comb begin
    case (cur_cnt)
      3'd0:    fbyte = cfg.frame_codes[7:0];
      3'd1:    fbyte = LEN_CODE;
      3'd2:    fbyte = cfg.frame_codes[15:8];
      3'd3:    fbyte = addr[7:0];
      3'd4:    fbyte = addr[15:8];
      3'd5:    fbyte = cfg.frame_codes[23:16];
      default: fbyte = csum;
    endcase
  end

  // Track progress through a request frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (emit) begin
      busy_r <= !cur_last;
      cnt_r  <= cur_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.kind       <= cur.kind;
      res_r.tx_byte    <= (cur.kind == KIND_REQ) ? fbyte : 8'd0;
      res_r.item       <= cur.item;
      res_r.reading    <= cur.reading;
      res_r.round_done <= cur.round_done;
      res_r.last       <= cur_last;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  a_busy_is_request: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.kind == KIND_REQ))
    else $error("frame in flight for a non-request job");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 3'd0 && cnt_r <= LAST_BYTE))
    else $error("frame byte count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/register_poll_read_engine.sv
// Top level of the register poll read engine: configuration registers and front/queue/back.
`default_nettype none

// Polls up to ITEM_COUNT meter register addresses over a serial link. Each input
// transaction is a millisecond tick (in_tuser 0) or a received byte (in_tuser 1). After
// poll_interval idle ticks the current item is taken: a skipped item is passed over with
// no result and the interval starts again for the next one; any other item gets a 7-byte
// read request, sent as seven result transactions (out_tuser 0). A good 6-byte reply
// gives one reading result (out_tuser 1), and a timeout after SEND_ATTEMPTS sends gives
// one failure result (out_tuser 2). out_tlast marks the final result caused by an input.
// Input transactions are taken one per cycle while the two-entry job queue has room; the
// back end delivers one result per cycle while the receiver takes them, so a starting tick
// gives seven results and a reading or failure one. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and should change only while no results are pending.
module register_poll_read_engine #(
  parameter int ITEM_COUNT    = 8,
  parameter int SEND_ATTEMPTS = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // rx_byte[7:0]
  input  wire         in_tuser,   // req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // tx_byte[7:0], item_index[10:8], reading[34:11],
                                  // round_done[35], zero[39:36]
  output logic [1:0]  out_tuser,  // out_kind
  output logic        out_tlast,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_wdata
);
  import rpre_pkg::*;

  logic [31:0] frame_codes_r;
  logic [15:0] poll_interval_r;
  logic [15:0] reply_timeout_r;
  logic [63:0] addr_low_r;
  logic [63:0] addr_high_r;
  logic [7:0]  skip_mask_r;

  front_cfg_t fcfg;
  back_cfg_t  bcfg;
  logic       q_full, push, pop, q_valid;
  job_t       push_job, head_job;
  res_t       res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_codes_r   <= '0;
      poll_interval_r <= 16'd1000;
      reply_timeout_r <= 16'd50;
      addr_low_r      <= '0;
      addr_high_r     <= '0;
      skip_mask_r     <= 8'h30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_CODES:   frame_codes_r   <= cfg_wdata[31:0];
        CFG_POLL_INTERVAL: poll_interval_r <= cfg_wdata[15:0];
        CFG_REPLY_TIMEOUT: reply_timeout_r <= cfg_wdata[15:0];
        CFG_ADDR_LOW:      addr_low_r      <= cfg_wdata;
        CFG_ADDR_HIGH:     addr_high_r     <= cfg_wdata;
        CFG_SKIP_MASK:     skip_mask_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign fcfg.poll_interval = poll_interval_r;
  assign fcfg.reply_timeout = reply_timeout_r;
  assign fcfg.skip_mask     = skip_mask_r;
  assign fcfg.ack_code      = frame_codes_r[31:24];
  assign bcfg.frame_codes   = frame_codes_r;
  assign bcfg.addr_low      = addr_low_r;
  assign bcfg.addr_high     = addr_high_r;

  rpre_front #(
    .ITEM_COUNT    (ITEM_COUNT),
    .SEND_ATTEMPTS (SEND_ATTEMPTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (fcfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .req_type (in_tuser),
    .rx_byte  (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rpre_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  rpre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (bcfg),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result transaction
  assign out_tdata = {4'd0, res.round_done, res.reading, res.item, res.tx_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Stream-level test of the register poll read engine against a cycle-free model of its behavior.
`default_nettype none

module testbench;
  import rpre_pkg::*;

  localparam int N_ITEMS       = 8;
  localparam int SEND_ATTEMPTS = 2;
  localparam int SETTLE        = 16;      // cycles for the front/queue/back to go quiet
  localparam int HOLD_CYCLES   = 300;     // one long receiver hold-off
  localparam int LIMIT         = 400000;  // cycle budget for the whole run

  // Ports
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // rx_byte[7:0]
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // tx_byte[7:0], item_index[10:8], reading[34:11],
                           // round_done[35], zero[39:36]
  logic [1:0]  out_tuser;  // out_kind
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  register_poll_read_engine #(
    .ITEM_COUNT   (N_ITEMS),
    .SEND_ATTEMPTS(SEND_ATTEMPTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Engine copy: configuration
  logic [31:0] m_codes;
  logic [15:0] m_poll;
  logic [15:0] m_tmo;
  logic [63:0] m_alo;
  logic [63:0] m_ahi;
  logic [7:0]  m_skip;

  // Engine copy: state
  logic        m_wait;
  logic [2:0]  m_ptr;
  int          m_sends;
  logic [15:0] m_rtmr;
  logic [15:0] m_ival;
  logic [7:0]  m_rbuf [0:5];
  logic [2:0]  m_rcnt;
  logic        m_round;

  // Results of one engine step, and the results still owed by the block
  res_t        step_res [0:6];
  int          step_n;
  res_t        engine_out_q [$];

  // Link items waiting to be offered: {req_type, rx_byte}
  logic [8:0]  link_item_q [$];

  // Directed plan
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] val;
    logic        rt;
    logic [7:0]  b;
    bit          typed;
    int          n;
    res_t        fin;
  } plan_row_t;
  plan_row_t   plan [$];

  int          bad_results;
  int          work_items;
  int          cycle_count;
  bit          hold_go;
  bit          steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle budget
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic res_t make_res(kind_t k, logic [7:0] tx, logic [2:0] it, logic [23:0] rd);
    res_t r;
    r.kind       = k;
    r.tx_byte    = tx;
    r.item       = it;
    r.reading    = rd;
    r.round_done = m_round;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic report_bad(input string tag, input res_t e, input res_t a);
    bad_results++;
    if (bad_results <= 10)
      $display("%s: expected kind %0d tx %02h item %0d reading %06h round %0b last %0b; got kind %0d tx %02h item %0d reading %06h round %0b last %0b",
               tag, e.kind, e.tx_byte, e.item, e.reading, e.round_done, e.last,
               a.kind, a.tx_byte, a.item, a.reading, a.round_done, a.last);
  endtask

  // Advance to the next table entry; wrapping marks a completed round
  task automatic next_item();
    if (m_ptr == 3'(N_ITEMS - 1)) begin
      m_ptr   = 3'd0;
      m_round = 1'b1;
    end else begin
      m_ptr = m_ptr + 3'd1;
    end
    m_ival = 16'd0;
  endtask

  // Build the seven request bytes for the current item
  task automatic load_frame();
    logic [7:0]  frame [0:6];
    logic [15:0] addr;
    logic [7:0]  sum;
    int          i;
    addr = m_ptr[2] ? m_ahi[{m_ptr[1:0], 4'd0} +: 16] : m_alo[{m_ptr[1:0], 4'd0} +: 16];
    frame[0] = m_codes[7:0];
    frame[1] = LEN_CODE;
    frame[2] = m_codes[15:8];
    frame[3] = addr[7:0];
    frame[4] = addr[15:8];
    frame[5] = m_codes[23:16];
    sum = 8'd0;
    for (i = 0; i < 6; i++) sum = sum + frame[i];
    frame[6] = 8'd0 - sum;
    for (i = 0; i < 7; i++) step_res[i] = make_res(KIND_REQ, frame[i], m_ptr, 24'd0);
    step_n = 7;
    m_rtmr = 16'd0;
    m_rcnt = 3'd0;
  endtask

  // One tick or received byte through the engine copy
  task automatic engine_step(input logic rt, input logic [7:0] b);
    logic [7:0] sum;
    logic [2:0] idx;
    int         i;
    step_n = 0;
    if (!m_wait) begin
      if (rt == REQ_BYTE) return;
      if (m_ival != 16'hFFFF) m_ival = m_ival + 16'd1;
      if (m_ival < m_poll) return;
      if (m_skip[m_ptr]) begin
        next_item();
        return;
      end
      load_frame();
      m_sends = 0;
      m_wait  = 1'b1;
    end else if (rt == REQ_BYTE) begin
      if (m_rcnt >= 3'd6) m_rcnt = 3'd0;
      m_rbuf[m_rcnt] = b;
      m_rcnt = m_rcnt + 3'd1;
      if (m_rcnt < 3'd6) return;
      m_rcnt = 3'd0;
      sum = 8'd0;
      for (i = 0; i < 5; i++) sum = sum + m_rbuf[i];
      // drop a bad frame and keep gathering
      if (m_rbuf[0] != m_codes[31:24] || m_rbuf[5] != 8'd0 - sum) return;
      idx = m_ptr;
      next_item();
      m_wait = 1'b0;
      step_res[0] = make_res(KIND_VALID, 8'd0, idx, {m_rbuf[4], m_rbuf[3], m_rbuf[2]});
      step_n = 1;
    end else begin
      if (m_rtmr != 16'hFFFF) m_rtmr = m_rtmr + 16'd1;
      if (m_rtmr < m_tmo) return;
      m_sends++;
      if (m_sends < SEND_ATTEMPTS) begin
        load_frame();
      end else begin
        idx = m_ptr;
        next_item();
        m_wait  = 1'b0;
        m_rcnt  = 3'd0;
        m_sends = 0;
        step_res[0] = make_res(KIND_FAIL, 8'd0, idx, 24'd0);
        step_n = 1;
      end
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endtask

  // Offer one transaction with random gaps; update the engine copy on acceptance
  task automatic send_item(input logic rt, input logic [7:0] b);
    int i;
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rt;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (m_wait || rt == REQ_TICK) work_items++;
    engine_step(rt, b);
    for (i = 0; i < step_n; i++) engine_out_q.push_back(step_res[i]);
    @(negedge clk);
  endtask

  // Hold the sender until every owed result is out and the block is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (engine_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FRAME_CODES:   m_codes = val[31:0];
      CFG_POLL_INTERVAL: m_poll  = val[15:0];
      CFG_REPLY_TIMEOUT: m_tmo   = val[15:0];
      CFG_ADDR_LOW:      m_alo   = val;
      CFG_ADDR_HIGH:     m_ahi   = val;
      CFG_SKIP_MASK:     m_skip  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void plan_cfg(logic [2:0] idx, logic [63:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(logic rt, logic [7:0] b);
    plan_row_t r;
    r = '{default: '0};
    r.rt = rt;
    r.b  = b;
    plan.push_back(r);
  endfunction

  function automatic void plan_check(logic rt, logic [7:0] b, int n, kind_t k, logic [7:0] tx,
                                     logic [2:0] it, logic [23:0] rd, logic rnd);
    plan_row_t r;
    r = '{default: '0};
    r.rt    = rt;
    r.b     = b;
    r.typed = 1'b1;
    r.n     = n;
    r.fin.kind       = k;
    r.fin.tx_byte    = tx;
    r.fin.item       = it;
    r.fin.reading    = rd;
    r.fin.round_done = rnd;
    r.fin.last       = 1'b1;
    plan.push_back(r);
  endfunction

  // Queue one burst of link traffic shaped by where the engine stands
  task automatic plan_burst();
    logic [7:0] ack;
    logic [7:0] sum;
    logic [7:0] rep [0:5];
    int         r;
    int         k;
    int         i;
    ack = m_codes[31:24];
    r   = $urandom_range(0, 99);
    if (!m_wait) begin
      if (r < 90) link_item_q.push_back({REQ_TICK, 8'h00});
      else link_item_q.push_back({REQ_BYTE, 8'($urandom)});
    end else if (r < 70) begin
      // realign when a partial frame is held
      if (m_rcnt != 3'd0 && $urandom_range(0, 1) == 1)
        for (i = int'(m_rcnt); i < 6; i++) link_item_q.push_back({REQ_BYTE, 8'($urandom)});
      rep[0] = ack;
      sum = ack;
      for (i = 1; i < 5; i++) begin
        rep[i] = 8'($urandom);
        sum = sum + rep[i];
      end
      rep[5] = 8'd0 - sum;
      k = (r < 55) ? 3 : $urandom_range(0, 2);
      if (k == 0) rep[0] = rep[0] ^ 8'($urandom_range(1, 255));
      if (k == 1) rep[5] = rep[5] ^ 8'($urandom_range(1, 255));
      if (k == 2) begin
        for (i = $urandom_range(1, 5); i > 0; i--)
          link_item_q.push_back({REQ_BYTE, 8'($urandom)});
      end else begin
        for (i = 0; i < 6; i++) link_item_q.push_back({REQ_BYTE, rep[i]});
      end
    end else begin
      link_item_q.push_back({REQ_TICK, 8'h00});
    end
  endtask

  task automatic run_phase(input logic [31:0] codes, input logic [15:0] poll,
                           input logic [15:0] tmo, input logic [63:0] lo,
                           input logic [63:0] hi, input logic [7:0] skip,
                           input int count, input bit with_hold);
    int         target;
    logic [8:0] it;
    drain();
    write_reg(CFG_FRAME_CODES, {32'd0, codes});
    write_reg(CFG_POLL_INTERVAL, {48'd0, poll});
    write_reg(CFG_REPLY_TIMEOUT, {48'd0, tmo});
    write_reg(CFG_ADDR_LOW, lo);
    write_reg(CFG_ADDR_HIGH, hi);
    write_reg(CFG_SKIP_MASK, {56'd0, skip});
    if (with_hold) hold_go = 1'b1;
    target = work_items + count;
    while (work_items < target || link_item_q.size() != 0) begin
      if (link_item_q.size() == 0) plan_burst();
      it = link_item_q.pop_front();
      send_item(it[8], it[7:0]);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Compare each result transaction with the oldest owed one
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = kind_t'(out_tuser);
      got.tx_byte    = out_tdata[7:0];
      got.item       = out_tdata[10:8];
      got.reading    = out_tdata[34:11];
      got.round_done = out_tdata[35];
      got.last       = out_tlast;
      if (engine_out_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: kind %0d tx %02h item %0d reading %06h round %0b last %0b",
                   got.kind, got.tx_byte, got.item, got.reading, got.round_done, got.last);
      end else begin
        want = engine_out_q.pop_front();
        if (got != want || out_tdata[39:36] != 4'd0) report_bad("result", want, got);
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t row;
    int        i;
    bad_results = 0;
    work_items  = 0;
    hold_go     = 1'b0;
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = REQ_TICK;
    cfg_we      = 1'b0;
    cfg_index   = CFG_FRAME_CODES;
    cfg_wdata   = 64'd0;

    // reset values of the engine copy
    m_codes = 32'd0;
    m_poll  = 16'd1000;
    m_tmo   = 16'd50;
    m_alo   = 64'd0;
    m_ahi   = 64'd0;
    m_skip  = 8'h30;
    m_wait  = 1'b0;
    m_ptr   = 3'd0;
    m_sends = 0;
    m_rtmr  = 16'd0;
    m_ival  = 16'd0;
    m_rcnt  = 3'd0;
    m_round = 1'b0;
    for (i = 0; i < 6; i++) m_rbuf[i] = 8'h00;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, idle byte, zero timeout, resend and failure
    plan_check(REQ_TICK, 8'h00, 0, KIND_REQ, 8'h00, 3'd0, 24'd0, 1'b0);
    plan_check(REQ_BYTE, 8'hFF, 0, KIND_REQ, 8'h00, 3'd0, 24'd0, 1'b0);
    plan_cfg(CFG_POLL_INTERVAL, 64'd0);
    plan_cfg(CFG_REPLY_TIMEOUT, 64'd0);
    plan_check(REQ_TICK, 8'h00, 7, KIND_REQ, 8'hF9, 3'd0, 24'd0, 1'b0);
    plan_check(REQ_TICK, 8'h00, 7, KIND_REQ, 8'hF9, 3'd0, 24'd0, 1'b0);
    plan_check(REQ_TICK, 8'h00, 1, KIND_FAIL, 8'h00, 3'd0, 24'd0, 1'b0);
    // all-ones codes and low addresses, good reply
    plan_cfg(CFG_FRAME_CODES, 64'hFFFF_FFFF);
    plan_cfg(CFG_ADDR_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_cfg(CFG_ADDR_HIGH, 64'h1234_5678_9ABC_DEF0);
    plan_cfg(CFG_SKIP_MASK, 64'h00);
    plan_cfg(CFG_REPLY_TIMEOUT, 64'd1);
    plan_check(REQ_TICK, 8'h00, 7, KIND_REQ, 8'hFE, 3'd1, 24'd0, 1'b0);
    plan_item(REQ_BYTE, 8'hFF);
    plan_item(REQ_BYTE, 8'h00);
    plan_item(REQ_BYTE, 8'h12);
    plan_item(REQ_BYTE, 8'h34);
    plan_item(REQ_BYTE, 8'h56);
    plan_check(REQ_BYTE, 8'h65, 1, KIND_VALID, 8'h00, 3'd1, 24'h563412, 1'b0);
    // bad checksum, then resend and failure
    plan_item(REQ_TICK, 8'h00);
    plan_item(REQ_BYTE, 8'hFF);
    plan_item(REQ_BYTE, 8'h00);
    plan_item(REQ_BYTE, 8'h12);
    plan_item(REQ_BYTE, 8'h34);
    plan_item(REQ_BYTE, 8'h56);
    plan_check(REQ_BYTE, 8'h66, 0, KIND_REQ, 8'h00, 3'd0, 24'd0, 1'b0);
    plan_item(REQ_TICK, 8'h00);
    plan_check(REQ_TICK, 8'h00, 1, KIND_FAIL, 8'h00, 3'd2, 24'd0, 1'b0);
    // skipped item passes without a request
    plan_cfg(CFG_SKIP_MASK, 64'h08);
    plan_check(REQ_TICK, 8'h00, 0, KIND_REQ, 8'h00, 3'd0, 24'd0, 1'b0);
    plan_item(REQ_TICK, 8'h00);

    foreach (plan[p]) begin
      row = plan[p];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_item(row.rt, row.b);
        if (row.typed && (step_n != row.n || (step_n > 0 && step_res[step_n - 1] != row.fin)))
          report_bad("directed", row.fin, (step_n > 0) ? step_res[step_n - 1] : res_t'(0));
      end
    end

    // Random phases across settings, extremes included
    run_phase($urandom, 16'd0, 16'd1, {$urandom, $urandom}, {$urandom, $urandom},
              8'h00, 90, 1'b1);
    run_phase($urandom, 16'd2, 16'd3, {$urandom, $urandom}, {$urandom, $urandom},
              8'($urandom), 80, 1'b0);
    run_phase($urandom, 16'hFFFF, 16'd2, {$urandom, $urandom}, {$urandom, $urandom},
              8'h00, 15, 1'b0);
    run_phase($urandom, 16'd1, 16'hFFFF, {$urandom, $urandom}, {$urandom, $urandom},
              8'h00, 50, 1'b0);
    run_phase($urandom, 16'd0, 16'd1, {$urandom, $urandom}, {$urandom, $urandom},
              8'hFF, 20, 1'b0);
    steady = 1'b1;
    run_phase(32'd0, 16'd0, 16'd2, 64'd0, 64'd0, 8'($urandom), 60, 1'b0);
    steady = 1'b0;
    run_phase(32'hFFFF_FFFF, 16'd1, 16'd4, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 8'h55, 60, 1'b0);
    run_phase($urandom, 16'($urandom_range(0, 4)), 16'($urandom_range(1, 5)),
              {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 60, 1'b0);

    drain();
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: register_poll_read_engine.f
rtl/core/rpre_pkg.sv
rtl/core/rpre_front.sv
rtl/core/rpre_queue.sv
rtl/core/rpre_back.sv
rtl/core/register_poll_read_engine.sv
test/testbench.sv
